// File: hw/rtl/nfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared types and constants of the next-fit slot allocator
// ----------------------------------------------------------------------------
package nfsa_pkg;

  // number of slots in the table
  localparam int unsigned Slots = 64;
  // slot index width
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  // identifier and op field widths
  localparam int unsigned IdW   = 7;
  localparam int unsigned OpW   = 2;
  // width wide enough to compare an identifier against the slot count
  localparam int unsigned IdCmpW = (SlotW + 1 > IdW) ? SlotW + 1 : IdW;

  typedef enum logic [OpW-1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpQuery = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScanRd,
    StScanChk,
    StLookRd,
    StLookChk,
    StDone
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/nfsa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module nfsa_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(Depth)-1:0]         waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic [$clog2(Depth)-1:0]         raddr_i,
  output logic      [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/next_fit_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// next-fit identifier allocator over a table of occupancy bits
// ----------------------------------------------------------------------------
// The block keeps one occupancy bit per slot in a small ram and a rotating
// search start. Allocate (op 0) probes the slots one by one from the search
// start, with wrap-around, claims the first free one, moves the search start
// just past it and returns slot index plus one with ok set; with every slot in
// use it returns 0 and ok clear. Free (op 1) clears an identifier's slot and
// reports whether it was in use; query (op 2) only reports. A free or query
// with an identifier outside 1..Slots, and op 3, give a zero result and change
// nothing. One transaction is handled at a time: each slot probe is a ram read
// state and then a check state through the single ram read port, and free and
// query each take one lookup read and one check state. After reset the block
// runs a clearing pass, one ram entry per cycle, and holds in_stall_o high until
// it ends. A new transaction is taken while a finished result still waits at the
// output register.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [nfsa_pkg::OpW-1:0]   op_i,
  input  wire logic [nfsa_pkg::IdW-1:0]   slot_id_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [nfsa_pkg::IdW-1:0]   granted_id_o,
  output logic                            ok_o
);
  import nfsa_pkg::*;

  // sequencer state and counters
  state_e            state_q, state_d;
  logic [SlotW-1:0]  cnt_q, cnt_d;       // clear address, then probe count
  logic [SlotW-1:0]  probe_q, probe_d;
  logic [SlotW-1:0]  search_q, search_d;

  // latched request
  logic [OpW-1:0]    op_q, op_d;
  logic [IdW-1:0]    id_q, id_d;

  // pending result
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              res_ok_q, res_ok_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic              out_ok_q, out_ok_d;

  // ram port
  logic              ram_we;
  logic [SlotW-1:0]  ram_waddr;
  logic              ram_wdata;
  logic [SlotW-1:0]  ram_raddr;
  logic              ram_rdata;

  // helpers
  logic              in_acc;
  logic              out_free;
  logic              cnt_last;
  logic [SlotW-1:0]  probe_next;
  logic [IdCmpW-1:0] in_id_ext;
  logic              in_id_ok;
  logic [IdCmpW-1:0] id_ext;
  logic [SlotW-1:0]  id_slot;

  // only an idle sequencer takes a new transaction
  assign in_stall_o = (state_q != StIdle);

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_last   = (cnt_q == SlotW'(Slots - 1));
  // step to the next slot with wrap-around
  assign probe_next = (probe_q == SlotW'(Slots - 1)) ? '0 : probe_q + SlotW'(1);

  // identifier range check on the incoming request
  assign in_id_ext  = IdCmpW'(slot_id_i);
  assign in_id_ok   = (in_id_ext != '0) && (in_id_ext <= IdCmpW'(Slots));

  // slot index of the latched identifier
  assign id_ext     = IdCmpW'(id_q);
  assign id_slot    = SlotW'(id_ext - IdCmpW'(1));

  // occupancy store
  nfsa_ram #(
    .Width (1),
    .Depth (Slots)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (cnt_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          if (op_i == OpAlloc) begin
            state_d = StScanRd;
          end else if ((op_i inside {OpFree, OpQuery}) && in_id_ok) begin
            state_d = StLookRd;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScanRd:  state_d = StScanChk;
      StScanChk: begin
        // claimed a free slot, or the whole table was probed
        if (!ram_rdata || cnt_last) begin
          state_d = StDone;
        end else begin
          state_d = StScanRd;
        end
      end
      StLookRd:  state_d = StLookChk;
      StLookChk: state_d = StDone;
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:   state_d = StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = probe_q;
    ram_wdata   = 1'b0;
    ram_raddr   = probe_q;
    cnt_d       = cnt_q;
    probe_d     = probe_q;
    search_d    = search_q;
    op_d        = op_q;
    id_d        = id_q;
    res_id_d    = res_id_q;
    res_ok_d    = res_ok_q;
    out_id_d    = out_id_q;
    out_ok_d    = out_ok_q;
    // a waiting result leaves once the far side takes it
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      StClear: begin
        // clear one entry per cycle after reset
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = 1'b0;
        cnt_d     = cnt_last ? '0 : cnt_q + SlotW'(1);
      end
      StIdle: begin
        if (in_acc) begin
          op_d     = op_i;
          id_d     = slot_id_i;
          probe_d  = search_q;
          cnt_d    = '0;
          res_id_d = '0;
          res_ok_d = 1'b0;
        end
      end
      StScanRd: begin
        ram_raddr = probe_q;
      end
      StScanChk: begin
        if (!ram_rdata) begin
          // free slot found: claim it and move the search start past it
          ram_we    = 1'b1;
          ram_waddr = probe_q;
          ram_wdata = 1'b1;
          search_d  = probe_next;
          res_id_d  = IdW'({1'b0, probe_q} + (SlotW + 1)'(1));
          res_ok_d  = 1'b1;
        end else begin
          cnt_d   = cnt_q + SlotW'(1);
          probe_d = probe_next;
        end
      end
      StLookRd: begin
        ram_raddr = id_slot;
      end
      StLookChk: begin
        res_ok_d = ram_rdata;
        if (op_q == OpFree) begin
          ram_we    = 1'b1;
          ram_waddr = id_slot;
          ram_wdata = 1'b0;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_ok_d    = res_ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      search_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      search_q    <= search_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    probe_q  <= probe_d;
    op_q     <= op_d;
    id_q     <= id_d;
    res_id_q <= res_id_d;
    res_ok_q <= res_ok_d;
    out_id_q <= out_id_d;
    out_ok_q <= out_ok_d;
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = out_id_q;
  assign ok_o         = out_ok_q;

endmodule

`default_nettype wire
